>>> rtl/core/uafta_pkg.sv
// Shared types, constants and fold table for the UTF-8 accent folding block.
// Used by the front, queue, back and top-level modules.
`default_nettype none

package uafta_pkg;

  localparam logic [7:0] LEAD_ACCENT = 8'hC3;
  localparam logic [6:0] CASE_OFFSET = 7'h20;

  localparam logic [6:0] CH_A = 7'h61;
  localparam logic [6:0] CH_C = 7'h63;
  localparam logic [6:0] CH_E = 7'h65;
  localparam logic [6:0] CH_I = 7'h69;
  localparam logic [6:0] CH_N = 7'h6E;
  localparam logic [6:0] CH_O = 7'h6F;
  localparam logic [6:0] CH_U = 7'h75;
  localparam logic [6:0] CH_NONE = 7'h00;

  typedef enum logic [1:0] {
    KIND_DROP,
    KIND_PASS,
    KIND_FOLD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic skip_busy;
    logic accent_pending;
  } fe_stat_t;

  // Lower-case letter for a 0xC3 follower by its low five bits; CH_NONE drops.
  function automatic logic [6:0] fold_lower(input logic [4:0] idx);
    logic [6:0] ch;
    case (idx) inside
      [5'd0:5'd5]:   ch = CH_A;
      5'd7:          ch = CH_C;
      [5'd8:5'd11]:  ch = CH_E;
      [5'd12:5'd15]: ch = CH_I;
      5'd17:         ch = CH_N;
      [5'd18:5'd22]: ch = CH_O;
      [5'd25:5'd28]: ch = CH_U;
      default:       ch = CH_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] fold_follower(input logic [7:0] b);
    logic [6:0] ch;
    ch = CH_NONE;
    if (b[7:6] == 2'b10) begin
      ch = fold_lower(b[4:0]);
      if (ch != CH_NONE && !b[5]) begin
        ch = ch - CASE_OFFSET;
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/utf8_accent_fold_to_ascii.sv
// UTF-8 to ASCII accent folding, top level.
// Depends on uafta_pkg, uafta_front, uafta_queue and uafta_back.
//
// Takes one UTF-8 byte per cycle while in_ready is high and gives exactly one
// result per byte: an ASCII character with out_valid high, or a dropped slot
// with out_valid low; out_end_of_text repeats in_last. Throughput is one
// byte per clock when neither side stalls, set by the combinational decode
// in the front end and the output register in the back end. A queue of
// QUEUE_DEPTH entries (at least 2) lets input and output stall apart.
`default_nettype none

module utf8_accent_fold_to_ascii #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_res_valid,
  input  wire logic        out_res_ready,
  output logic [6:0]       out_byte,
  output logic             out_valid,
  output logic             out_end_of_text
);
  import uafta_pkg::*;

  q_stat_t   q_stat;
  q_entry_t  push_data;
  q_entry_t  pop_data;
  fe_stat_t  fe_stat;
  logic      push;
  logic      pop;

  uafta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data),
    .fe_stat   (fe_stat)
  );

  uafta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  uafta_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_res_valid   (out_res_valid),
    .out_res_ready   (out_res_ready),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_end_of_text (out_end_of_text)
  );

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !fe_stat.skip_busy && !fe_stat.accent_pending)
    else $error("sequence state not cleared after last byte");

  a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(fe_stat.skip_busy && fe_stat.accent_pending))
    else $error("skip and accent states both active");

  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty && !out_res_valid |=> out_res_valid)
    else $error("queued request not moved to output");
`endif

endmodule

`default_nettype wire

>>> rtl/core/uafta_front.sv
// Front end: accept input bytes, track multi-byte sequence state, classify.
// Depends on uafta_pkg.
`default_nettype none

module uafta_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  input  wire uafta_pkg::q_stat_t   q_stat,
  output logic                      push,
  output uafta_pkg::q_entry_t       push_data,
  output uafta_pkg::fe_stat_t       fe_stat
);
  import uafta_pkg::*;

  logic [1:0] skip_r, skip_nxt;
  logic       acc_r, acc_nxt;
  kind_t      kind;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    skip_nxt = skip_r;
    acc_nxt  = acc_r;
    kind     = KIND_DROP;
    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (acc_r) begin
      acc_nxt = 1'b0;
      kind    = KIND_FOLD;
    end else if (!in_byte[7]) begin
      kind = KIND_PASS;
    end else if (in_byte == LEAD_ACCENT) begin
      acc_nxt = 1'b1;
    end else if (in_byte[7:5] == 3'b110) begin
      skip_nxt = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      skip_nxt = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      skip_nxt = 2'd3;
    end
    if (in_last) begin
      skip_nxt = 2'd0;
      acc_nxt  = 1'b0;
    end
  end

  assign push_data.kind = kind;
  assign push_data.data = in_byte;
  assign push_data.last = in_last;

  assign fe_stat.skip_busy      = (skip_r != 2'd0);
  assign fe_stat.accent_pending = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 2'd0;
      acc_r  <= 1'b0;
    end else if (push) begin
      skip_r <= skip_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uafta_queue.sv
// Short request queue between front and back ends.
// Depends on uafta_pkg.
`default_nettype none

module uafta_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire uafta_pkg::q_entry_t  push_data,
  input  wire logic                 pop,
  output uafta_pkg::q_entry_t       pop_data,
  output uafta_pkg::q_stat_t        q_stat
);
  import uafta_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uafta_back.sv
// Back end: fold queued requests into ASCII and hold them in the output register.
// Depends on uafta_pkg.
`default_nettype none

module uafta_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire uafta_pkg::q_stat_t   q_stat,
  input  wire uafta_pkg::q_entry_t  pop_data,
  output logic                      pop,
  output logic                      out_res_valid,
  input  wire logic                 out_res_ready,
  output logic [6:0]                out_byte,
  output logic                      out_valid,
  output logic                      out_end_of_text
);
  import uafta_pkg::*;

  logic       vld_r;
  logic [6:0] ch_r;
  logic       chv_r;
  logic       eot_r;
  logic [6:0] ch_nxt;
  logic       chv_nxt;
  logic [6:0] folded;

  assign pop    = !q_stat.empty && (!vld_r || out_res_ready);
  assign folded = fold_follower(pop_data.data);

  always_comb begin
    case (pop_data.kind)
      KIND_PASS: begin
        ch_nxt  = pop_data.data[6:0];
        chv_nxt = 1'b1;
      end
      KIND_FOLD: begin
        ch_nxt  = folded;
        chv_nxt = (folded != CH_NONE);
      end
      default: begin
        ch_nxt  = CH_NONE;
        chv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (out_res_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch_r  <= ch_nxt;
      chv_r <= chv_nxt;
      eot_r <= pop_data.last;
    end
  end

  assign out_res_valid   = vld_r;
  assign out_byte        = ch_r;
  assign out_valid       = chv_r;
  assign out_end_of_text = eot_r;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_accent_fold_to_ascii: directed table, then random UTF-8.
// Drives bytes over valid/ready with random gaps and stalls, checks against an inline folder.
// Depends only on the utf8_accent_fold_to_ascii RTL and its package.

module tb_top;

  localparam logic [7:0] LEAD_FOLD = 8'hC3;
  localparam logic [6:0] ASC_A = 7'h61;
  localparam logic [6:0] ASC_C = 7'h63;
  localparam logic [6:0] ASC_E = 7'h65;
  localparam logic [6:0] ASC_I = 7'h69;
  localparam logic [6:0] ASC_N = 7'h6E;
  localparam logic [6:0] ASC_O = 7'h6F;
  localparam logic [6:0] ASC_U = 7'h75;
  localparam logic [6:0] ASC_NONE = 7'h00;
  localparam logic [6:0] UPPER_SHIFT = 7'h20;
  localparam int RANDOM_BYTES = 1600;
  localparam int MAX_GAP = 12;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [6:0] ch;
    logic       valid;
    logic       eot;
  } fold_result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic [6:0] ch;
    logic       v;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_res_valid;
  logic       out_res_ready;
  logic [6:0] out_byte;
  logic       out_valid;
  logic       out_end_of_text;

  fold_result_t expected_chars[$];
  int           mismatch_count = 0;
  logic [1:0]   bytes_to_skip = 2'd0;
  logic         accent_wait = 1'b0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h41, 1'b0, 1'b1, 7'h41, 1'b1},
    '{8'h01, 1'b0, 1'b1, 7'h01, 1'b1},
    '{8'h7F, 1'b0, 1'b1, 7'h7F, 1'b1},
    '{8'h80, 1'b0, 1'b1, 7'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 7'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h89, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hB1, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h41, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hC2, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h41, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h80, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h99, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'h98, 1'b1, 1'b0, 7'h00, 1'b0},
    '{8'h41, 1'b0, 1'b0, 7'h00, 1'b0},
    '{8'hC3, 1'b1, 1'b0, 7'h00, 1'b0},
    '{8'hA9, 1'b1, 1'b0, 7'h00, 1'b0},
    '{8'hF8, 1'b1, 1'b1, 7'h00, 1'b0}
  };

  utf8_accent_fold_to_ascii DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_res_valid   (out_res_valid),
    .out_res_ready   (out_res_ready),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_end_of_text (out_end_of_text)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [6:0] fold_letter(input logic [7:0] b);
    logic [4:0] idx;
    logic [6:0] letter;
    idx = b[4:0];
    letter = ASC_NONE;
    if (b[7:6] == 2'b10) begin
      if (idx <= 5'd5) letter = ASC_A;
      else if (idx == 5'd7) letter = ASC_C;
      else if (idx >= 5'd8 && idx <= 5'd11) letter = ASC_E;
      else if (idx >= 5'd12 && idx <= 5'd15) letter = ASC_I;
      else if (idx == 5'd17) letter = ASC_N;
      else if (idx >= 5'd18 && idx <= 5'd22) letter = ASC_O;
      else if (idx >= 5'd25 && idx <= 5'd28) letter = ASC_U;
      if (letter != ASC_NONE && !b[5]) letter = letter - UPPER_SHIFT;
    end
    return letter;
  endfunction

  function automatic fold_result_t ascii_fold_predict(input logic [7:0] b, input logic l);
    fold_result_t r;
    r = '{ch: ASC_NONE, valid: 1'b0, eot: l};
    if (bytes_to_skip != 2'd0) begin
      bytes_to_skip = bytes_to_skip - 2'd1;
    end else if (accent_wait) begin
      accent_wait = 1'b0;
      r.ch = fold_letter(b);
      r.valid = (r.ch != ASC_NONE);
    end else if (b < 8'h80) begin
      r.ch = b[6:0];
      r.valid = 1'b1;
    end else if (b == LEAD_FOLD) begin
      accent_wait = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      bytes_to_skip = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      bytes_to_skip = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      bytes_to_skip = 2'd3;
    end
    if (l) begin
      bytes_to_skip = 2'd0;
      accent_wait = 1'b0;
    end
    return r;
  endfunction

  task automatic send_request(input logic [7:0] b, input logic l, input logic typed,
                              input fold_result_t typed_res);
    int gap;
    fold_result_t predicted;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (!in_ready);
    predicted = ascii_fold_predict(b, l);
    expected_chars.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_request(b, ($urandom_range(0, 24) == 0), 1'b0, '0);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int pick;
    int sent;
    fold_result_t row_res;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h20;
    in_last = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row_res = '{ch: directed_rows[i].ch, valid: directed_rows[i].v, eot: directed_rows[i].l};
      send_request(directed_rows[i].b, directed_rows[i].l, directed_rows[i].typed, row_res);
    end

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_plain(8'($urandom_range(1, 127)));
        sent += 1;
      end else if (pick < 60) begin
        send_plain(LEAD_FOLD);
        if ($urandom_range(0, 4) != 0) send_plain(8'($urandom_range(8'h80, 8'hBF)));
        else send_plain(8'($urandom_range(1, 255)));
        sent += 2;
      end else if (pick < 70) begin
        send_plain(8'($urandom_range(8'hC0, 8'hDF)));
        send_plain(cont_byte());
        sent += 2;
      end else if (pick < 80) begin
        send_plain(8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) send_plain(cont_byte());
        sent += 3;
      end else if (pick < 88) begin
        send_plain(8'($urandom_range(8'hF0, 8'hF7)));
        repeat (3) send_plain(cont_byte());
        sent += 4;
      end else begin
        send_plain(8'($urandom_range(1, 255)));
        sent += 1;
      end
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("utf8_accent_fold_to_ascii verification clean");
    end else begin
      $display("utf8_accent_fold_to_ascii verification failed");
    end
    $finish;
  end

  initial begin
    int gap;
    fold_result_t exp_res;
    out_res_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_res_ready <= 1'b1;
      do @(posedge clk); while (!out_res_valid);
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_byte %0h out_valid %0b out_end_of_text %0b",
               out_byte, out_valid, out_end_of_text);
        mismatch_count++;
      end else begin
        exp_res = expected_chars.pop_front();
        if (out_byte !== exp_res.ch) begin
          $error("out_byte: expected %0h actual %0h", exp_res.ch, out_byte);
          mismatch_count++;
        end
        if (out_valid !== exp_res.valid) begin
          $error("out_valid: expected %0b actual %0b", exp_res.valid, out_valid);
          mismatch_count++;
        end
        if (out_end_of_text !== exp_res.eot) begin
          $error("out_end_of_text: expected %0b actual %0b", exp_res.eot, out_end_of_text);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("utf8_accent_fold_to_ascii verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/uafta_pkg.sv
rtl/core/uafta_front.sv
rtl/core/uafta_queue.sv
rtl/core/uafta_back.sv
rtl/core/utf8_accent_fold_to_ascii.sv
dv/tb_top.sv
